// ===== sv/pmso_pkg.sv =====
// Shared types, widths and constants for the polygon metrics block.
// No dependencies; the cross unit, the square root unit, the top block and the testbench import this package.
`timescale 1ns / 1ps

package pmso_pkg;

  // Coordinate and result widths
  localparam int unsigned COORD_BITS     = 16;
  localparam int unsigned MAX_VERTICES   = 65536;
  localparam int unsigned MIN_POINTS     = 3;
  localparam int unsigned TERM_BITS      = 2 * COORD_BITS + 1;
  localparam int unsigned SQ_BITS        = 2 * COORD_BITS + 1;
  localparam int unsigned ROOT_BITS      = COORD_BITS + 1;
  localparam int unsigned RAD_BITS       = 2 * ROOT_BITS;
  localparam int unsigned CROSS_BITS     = 50;
  localparam int unsigned AREA_BITS      = 48;
  localparam int unsigned PERIM_BITS     = 40;
  localparam int unsigned COUNT_OUT_BITS = 17;
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 48;

  // Saturation limits
  localparam logic signed [CROSS_BITS-1:0] CROSS_LIMIT = {1'b0, {(CROSS_BITS - 1){1'b1}}};
  localparam logic [AREA_BITS-1:0]         AREA_MAX      = '1;
  localparam logic [PERIM_BITS-1:0]        PERIM_MAX     = '1;
  localparam logic [COUNT_OUT_BITS-1:0]    COUNT_OUT_MAX = '1;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FILTER_ENABLED   = 3'd0,
    REG_MIN_DOUBLED_AREA = 3'd1,
    REG_MIN_WIDTH        = 3'd2,
    REG_MIN_HEIGHT       = 3'd3,
    REG_MIN_PERIMETER    = 3'd4
  } pmso_reg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQUARE,
    ST_ROOT,
    ST_ACC,
    ST_AREA,
    ST_EMIT
  } pmso_state_e;

  // Channel payloads
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         last;
  } pmso_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] min_x;
    logic signed [COORD_BITS-1:0] max_x;
    logic signed [COORD_BITS-1:0] min_y;
    logic signed [COORD_BITS-1:0] max_y;
    logic [COORD_BITS-1:0]        box_width;
    logic [COORD_BITS-1:0]        box_height;
    logic [AREA_BITS-1:0]         doubled_area;
    logic [PERIM_BITS-1:0]        perimeter;
    logic [COUNT_OUT_BITS-1:0]    point_count;
    logic                         too_small;
  } pmso_out_t;

  typedef struct packed {
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  value;
  } pmso_cfg_t;

  // Control of a serial unit: load operands, then advance one digit per step
  typedef struct packed {
    logic load;
    logic step;
  } pmso_ser_ctrl_t;

  // Magnitude of b - a for two signed coordinates
  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic [COORD_BITS:0] d;
    logic [COORD_BITS:0] n;
    d = {b[COORD_BITS-1], b} - {a[COORD_BITS-1], a};
    n = -d;
    return d[COORD_BITS] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
  endfunction

endpackage

// ===== sv/pmso_stream_if.sv =====
// Valid/ready channel carrying one payload of type T per transfer.
// Used for the vertex input, the result output and the configuration writes.
`timescale 1ns / 1ps

interface pmso_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/pmso_cross.sv =====
// Bit-serial shoelace term ax*by - bx*ay, one multiplier bit per step.
// Depends on pmso_pkg.
`timescale 1ns / 1ps

module pmso_cross (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  pmso_pkg::pmso_ser_ctrl_t               ctrl_i,
  input  logic signed [pmso_pkg::COORD_BITS-1:0] ax_i,
  input  logic signed [pmso_pkg::COORD_BITS-1:0] ay_i,
  input  logic signed [pmso_pkg::COORD_BITS-1:0] bx_i,
  input  logic signed [pmso_pkg::COORD_BITS-1:0] by_i,
  output logic signed [pmso_pkg::TERM_BITS-1:0]  term_o
);
  import pmso_pkg::*;

  localparam int unsigned CntBits = $clog2(COORD_BITS + 1);
  localparam logic [CntBits-1:0] CntDone = CntBits'(COORD_BITS);
  localparam logic [CntBits-1:0] CntSign = CntBits'(COORD_BITS - 1);
  localparam logic signed [TERM_BITS-1:0] TermZero = '0;

  logic [CntBits-1:0]          cnt_q;
  logic signed [TERM_BITS-1:0] mcand_a_q, mcand_b_q, acc_q;
  logic [COORD_BITS-1:0]       mplr_a_q, mplr_b_q;
  logic signed [TERM_BITS-1:0] part, acc_d;
  logic                        active;

  assign active = ctrl_i.step && (cnt_q != CntDone);

  // Partial product of this bit; the sign bit of the multiplier weighs negative
  always_comb begin
    part  = (mplr_a_q[0] ? mcand_a_q : TermZero) - (mplr_b_q[0] ? mcand_b_q : TermZero);
    acc_d = (cnt_q == CntSign) ? acc_q - part : acc_q + part;
  end

  // Count bits taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.load) begin
      cnt_q <= '0;
    end else if (active) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Shift multiplicands up and multipliers down, accumulate
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mcand_a_q <= TERM_BITS'(ax_i);
      mcand_b_q <= TERM_BITS'(bx_i);
      mplr_a_q  <= by_i;
      mplr_b_q  <= ay_i;
      acc_q     <= TermZero;
    end else if (active) begin
      mcand_a_q <= mcand_a_q <<< 1;
      mcand_b_q <= mcand_b_q <<< 1;
      mplr_a_q  <= mplr_a_q >> 1;
      mplr_b_q  <= mplr_b_q >> 1;
      acc_q     <= acc_d;
    end
  end

  assign term_o = acc_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntDone)
    else $error("cross unit bit counter ran past the multiplier width");

endmodule

// ===== sv/pmso_isqrt.sv =====
// Restoring floor square root, one root bit (two radicand bits) per step.
// Depends on pmso_pkg.
`timescale 1ns / 1ps

module pmso_isqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pmso_pkg::pmso_ser_ctrl_t        ctrl_i,
  input  logic [pmso_pkg::RAD_BITS-1:0]   radicand_i,
  output logic [pmso_pkg::ROOT_BITS-1:0]  root_o
);
  import pmso_pkg::*;

  localparam int unsigned RemBits = ROOT_BITS + 3;

  logic [RAD_BITS-1:0]  rad_q;
  logic [RemBits-1:0]   rem_q;
  logic [ROOT_BITS-1:0] root_q;
  logic [RemBits-1:0]   rem_shift, trial;
  logic                 fits;

  // Bring down the next bit pair and try the next root bit
  always_comb begin
    rem_shift = {rem_q[RemBits-3:0], rad_q[RAD_BITS-1 -: 2]};
    trial     = RemBits'({root_q, 2'b01});
    fits      = rem_shift >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      root_q <= '0;
    end else if (ctrl_i.load) begin
      rem_q  <= '0;
      root_q <= '0;
    end else if (ctrl_i.step) begin
      rem_q  <= fits ? rem_shift - trial : rem_shift;
      root_q <= {root_q[ROOT_BITS-2:0], fits};
    end
  end

  // Radicand shift register, two bits out per step
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rad_q <= radicand_i;
    end else if (ctrl_i.step) begin
      rad_q <= {rad_q[RAD_BITS-3:0], 2'b00};
    end
  end

  assign root_o = root_q;

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= RemBits'({root_q, 1'b0}))
    else $error("square root remainder exceeds twice the partial root");

endmodule

// ===== sv/polygon_metrics_small_object_test.sv =====
// Polygon metrics: takes one vertex per transfer and, on the vertex flagged last, returns the
// bounding box, doubled shoelace area, perimeter, point count and a small-object flag. The input
// stays ready after the first vertex of a polygon unless it is flagged last; every further
// vertex runs the states DIFF, SQUARE, ROOT and ACC before the input is ready again, ROOT being
// set by the bit-serial square root of the squared edge length (17 steps, one root bit each)
// with the serial cross product running alongside. The last vertex of a polygon of three or
// more points runs them again for the closing edge, and every last vertex passes the area and
// result stages; the result then sits in an output register, and the next polygon's result
// waits only if that one is still untaken. Configuration writes are taken at any time, one per
// cycle, and apply to every result formed after the write, so change them only between polygons.
// Depends on pmso_pkg, pmso_stream_if, pmso_cross and pmso_isqrt.
`timescale 1ns / 1ps

module polygon_metrics_small_object_test #(
  parameter int unsigned MaxVertices = pmso_pkg::MAX_VERTICES
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  pmso_stream_if.sink    in_i,
  pmso_stream_if.source  out_o,
  pmso_stream_if.sink    cfg_i
);
  import pmso_pkg::*;

  localparam int unsigned CountBits = $clog2(MaxVertices + 1);
  localparam int unsigned CmpBits   = (CountBits > COUNT_OUT_BITS) ? CountBits : COUNT_OUT_BITS;
  localparam int unsigned CrossWide = CROSS_BITS + 1;
  localparam int unsigned PerimWide = PERIM_BITS + 1;
  localparam int unsigned StepBits  = $clog2(ROOT_BITS);
  localparam logic [StepBits-1:0] StepLast = StepBits'(ROOT_BITS - 1);

  // Sequencer
  pmso_state_e state_q, state_d;
  logic        in_acc, out_free, emit_go, closing_needed, in_ready;
  pmso_ser_ctrl_t cross_ctrl, root_ctrl;

  // Configuration
  logic                  filter_en_q;
  logic [AREA_BITS-1:0]  min_area_q;
  logic [COORD_BITS-1:0] min_width_q, min_height_q;
  logic [PERIM_BITS-1:0] min_perim_q;

  // Polygon state
  logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [COORD_BITS-1:0] box_min_x_q, box_max_x_q, box_min_y_q, box_max_y_q;
  logic signed [CROSS_BITS-1:0] cross_sum_q;
  logic [PERIM_BITS-1:0]        edge_sum_q;
  logic [CountBits-1:0]         count_q;
  logic                         last_q, closing_q;

  // Edge datapath
  logic signed [COORD_BITS-1:0] edge_ax_q, edge_ay_q, edge_bx_q, edge_by_q;
  logic [COORD_BITS-1:0]        dx_q, dy_q;
  logic [StepBits-1:0]          step_q;
  logic [2*COORD_BITS-1:0]      sq_x, sq_y;
  logic [SQ_BITS-1:0]           sq_sum;
  logic signed [TERM_BITS-1:0]  term;
  logic [ROOT_BITS-1:0]         root;
  logic signed [CrossWide-1:0]  cross_wide;
  logic signed [CROSS_BITS-1:0] cross_next, cross_neg;
  logic [PerimWide-1:0]         edge_wide;
  logic [PERIM_BITS-1:0]        edge_next;

  // Result
  logic [CROSS_BITS-1:0]  cross_abs;
  logic [AREA_BITS-1:0]   area_q;
  logic [COORD_BITS:0]    w_wide, h_wide;
  logic [CmpBits-1:0]     count_ext;
  logic                   out_valid_q;
  pmso_out_t              out_q, result;

  assign in_acc   = in_i.valid && in_ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign closing_needed = last_q && !closing_q && (count_q >= CountBits'(MIN_POINTS));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (count_q != '0) begin
            state_d = ST_DIFF;
          end else if (in_i.data.last) begin
            state_d = ST_AREA;
          end
        end
      end
      ST_DIFF:   state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_ROOT;
      ST_ROOT: begin
        if (step_q == StepLast) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (closing_needed) begin
          state_d = ST_DIFF;
        end else if (last_q) begin
          state_d = ST_AREA;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_AREA:   state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready        = 1'b0;
    cross_ctrl.load = 1'b0;
    cross_ctrl.step = 1'b0;
    root_ctrl.load  = 1'b0;
    root_ctrl.step  = 1'b0;
    emit_go         = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready = 1'b1;
      ST_DIFF:   cross_ctrl.load = 1'b1;
      ST_SQUARE: root_ctrl.load = 1'b1;
      ST_ROOT: begin
        cross_ctrl.step = 1'b1;
        root_ctrl.step  = 1'b1;
      end
      ST_EMIT:   emit_go = out_free;
      default: ;
    endcase
  end

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_en_q  <= 1'b0;
      min_area_q   <= '0;
      min_width_q  <= '0;
      min_height_q <= '0;
      min_perim_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        REG_FILTER_ENABLED:   filter_en_q  <= cfg_i.data.value[0];
        REG_MIN_DOUBLED_AREA: min_area_q   <= cfg_i.data.value[AREA_BITS-1:0];
        REG_MIN_WIDTH:        min_width_q  <= cfg_i.data.value[COORD_BITS-1:0];
        REG_MIN_HEIGHT:       min_height_q <= cfg_i.data.value[COORD_BITS-1:0];
        REG_MIN_PERIMETER:    min_perim_q  <= cfg_i.data.value[PERIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Squared edge length for the root unit
  always_comb begin
    sq_x   = dx_q * dx_q;
    sq_y   = dy_q * dy_q;
    sq_sum = {1'b0, sq_x} + {1'b0, sq_y};
  end

  // Saturating cross sum and perimeter updates
  always_comb begin
    cross_wide = CrossWide'(cross_sum_q) + CrossWide'(term);
    if (cross_wide > CrossWide'(CROSS_LIMIT)) begin
      cross_next = CROSS_LIMIT;
    end else if (cross_wide < -CrossWide'(CROSS_LIMIT)) begin
      cross_next = -CROSS_LIMIT;
    end else begin
      cross_next = cross_wide[CROSS_BITS-1:0];
    end
    edge_wide = {1'b0, edge_sum_q} + PerimWide'(root);
    edge_next = (edge_wide >= {1'b0, PERIM_MAX}) ? PERIM_MAX : edge_wide[PERIM_BITS-1:0];
  end

  // Hold the polygon state; clear it once the result is handed over
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q   <= '0;
      first_y_q   <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      box_min_x_q <= '0;
      box_max_x_q <= '0;
      box_min_y_q <= '0;
      box_max_y_q <= '0;
      cross_sum_q <= '0;
      edge_sum_q  <= '0;
      count_q     <= '0;
      last_q      <= 1'b0;
      closing_q   <= 1'b0;
    end else if (in_acc) begin
      prev_x_q  <= in_i.data.x;
      prev_y_q  <= in_i.data.y;
      last_q    <= in_i.data.last;
      closing_q <= 1'b0;
      if (count_q == '0) begin
        first_x_q   <= in_i.data.x;
        first_y_q   <= in_i.data.y;
        box_min_x_q <= in_i.data.x;
        box_max_x_q <= in_i.data.x;
        box_min_y_q <= in_i.data.y;
        box_max_y_q <= in_i.data.y;
      end else begin
        if (in_i.data.x < box_min_x_q) box_min_x_q <= in_i.data.x;
        if (in_i.data.x > box_max_x_q) box_max_x_q <= in_i.data.x;
        if (in_i.data.y < box_min_y_q) box_min_y_q <= in_i.data.y;
        if (in_i.data.y > box_max_y_q) box_max_y_q <= in_i.data.y;
      end
      if (count_q < CountBits'(MaxVertices)) begin
        count_q <= count_q + 1'b1;
      end
    end else if (state_q == ST_ACC) begin
      cross_sum_q <= cross_next;
      edge_sum_q  <= edge_next;
      if (closing_needed) begin
        closing_q <= 1'b1;
      end
    end else if (emit_go) begin
      first_x_q   <= '0;
      first_y_q   <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      box_min_x_q <= '0;
      box_max_x_q <= '0;
      box_min_y_q <= '0;
      box_max_y_q <= '0;
      cross_sum_q <= '0;
      edge_sum_q  <= '0;
      count_q     <= '0;
      last_q      <= 1'b0;
      closing_q   <= 1'b0;
    end
  end

  // Root step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (state_q == ST_SQUARE) begin
      step_q <= '0;
    end else if (state_q == ST_ROOT) begin
      step_q <= step_q + 1'b1;
    end
  end

  // Edge endpoints, differences and area magnitude
  always_comb begin
    cross_neg = -cross_sum_q;
    cross_abs = cross_sum_q[CROSS_BITS-1] ? $unsigned(cross_neg) : $unsigned(cross_sum_q);
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      edge_ax_q <= prev_x_q;
      edge_ay_q <= prev_y_q;
      edge_bx_q <= in_i.data.x;
      edge_by_q <= in_i.data.y;
    end else if (state_q == ST_ACC && closing_needed) begin
      edge_ax_q <= prev_x_q;
      edge_ay_q <= prev_y_q;
      edge_bx_q <= first_x_q;
      edge_by_q <= first_y_q;
    end
    if (state_q == ST_DIFF) begin
      dx_q <= abs_diff(edge_ax_q, edge_bx_q);
      dy_q <= abs_diff(edge_ay_q, edge_by_q);
    end
    if (state_q == ST_AREA) begin
      area_q <= (cross_abs > CROSS_BITS'(AREA_MAX)) ? AREA_MAX : cross_abs[AREA_BITS-1:0];
    end
  end

  pmso_cross u_cross (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cross_ctrl),
    .ax_i   (edge_ax_q),
    .ay_i   (edge_ay_q),
    .bx_i   (edge_bx_q),
    .by_i   (edge_by_q),
    .term_o (term)
  );

  pmso_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (root_ctrl),
    .radicand_i (RAD_BITS'(sq_sum)),
    .root_o     (root)
  );

  // Assemble the result; degenerate polygons report only count and flag
  always_comb begin
    w_wide    = {box_max_x_q[COORD_BITS-1], box_max_x_q} - {box_min_x_q[COORD_BITS-1], box_min_x_q};
    h_wide    = {box_max_y_q[COORD_BITS-1], box_max_y_q} - {box_min_y_q[COORD_BITS-1], box_min_y_q};
    count_ext = CmpBits'(count_q);
    result    = '0;
    result.point_count = (count_ext > CmpBits'(COUNT_OUT_MAX)) ? COUNT_OUT_MAX
                                                               : count_ext[COUNT_OUT_BITS-1:0];
    if (count_q < CountBits'(MIN_POINTS)) begin
      result.too_small = filter_en_q;
    end else begin
      result.min_x        = box_min_x_q;
      result.max_x        = box_max_x_q;
      result.min_y        = box_min_y_q;
      result.max_y        = box_max_y_q;
      result.box_width    = w_wide[COORD_BITS-1:0];
      result.box_height   = h_wide[COORD_BITS-1:0];
      result.doubled_area = area_q;
      result.perimeter    = edge_sum_q;
      result.too_small    = filter_en_q && ((area_q < min_area_q) ||
                            (w_wide[COORD_BITS-1:0] < min_width_q) ||
                            (h_wide[COORD_BITS-1:0] < min_height_q) ||
                            (edge_sum_q < min_perim_q));
    end
  end

  // Output register: load on emit, drop once the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_go) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_edge_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (count_q != '0) |=> state_q == ST_DIFF)
    else $error("vertex after the first did not start an edge");

  a_closing_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC) && closing_needed |=> (state_q == ST_DIFF) && closing_q)
    else $error("closing edge not started after the last vertex");

  a_cross_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cross_sum_q <= CROSS_LIMIT) && (cross_sum_q >= -CROSS_LIMIT))
    else $error("cross sum outside its saturation range");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |=> out_valid_q && (count_q == '0))
    else $error("result not held or polygon state not cleared after emit");

endmodule

// ===== bench/polygon_metrics_small_object_test_tb.sv =====
// Testbench for polygon_metrics_small_object_test: streams polygons, predicts each result.
// Depends on pmso_pkg, pmso_stream_if and the block itself; reads no files.
`timescale 1ns / 1ps

module polygon_metrics_small_object_test_tb;
  import pmso_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned PHASE_ITEMS  = 130;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam longint      TERM_CLAMP   = 64'sh4_0000_0000_0000;

  typedef enum int unsigned {SHAPE_SCATTER, SHAPE_CLUSTER, SHAPE_CORNERS} shape_e;

  typedef struct {
    pmso_in_t  vtx;
    bit        typed;
    pmso_out_t want;
  } vertex_row_t;

  logic clk_i;
  logic rst_ni;

  pmso_stream_if #(.T(pmso_in_t))  vtx_if ();
  pmso_stream_if #(.T(pmso_out_t)) res_if ();
  pmso_stream_if #(.T(pmso_cfg_t)) cfg_if ();

  polygon_metrics_small_object_test u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (vtx_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  wire vtx_fire = vtx_if.valid && vtx_if.ready;
  wire res_fire = res_if.valid && res_if.ready;
  wire cfg_fire = cfg_if.valid && cfg_if.ready;

  // Shadow of the threshold registers
  logic                  filt_on;
  logic [AREA_BITS-1:0]  thr_area;
  logic [COORD_BITS-1:0] thr_width;
  logic [COORD_BITS-1:0] thr_height;
  logic [PERIM_BITS-1:0] thr_perim;

  // Polygon under construction
  longint          poly_first_x, poly_first_y, poly_prev_x, poly_prev_y;
  longint          box_lo_x, box_hi_x, box_lo_y, box_hi_y;
  longint          cross_acc;
  longint unsigned perim_acc;
  longint unsigned vtx_seen;

  pmso_out_t   metrics_due[$];
  vertex_row_t plan[$];
  bit          row_is_typed;
  pmso_out_t   row_want;
  bit          calm;
  int unsigned fault_count;
  int unsigned results_seen;
  int unsigned stim_items;
  int unsigned quiet_cycles;
  int unsigned hold_left;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void clear_shape();
    poly_first_x = 0; poly_first_y = 0; poly_prev_x = 0; poly_prev_y = 0;
    box_lo_x = 0; box_hi_x = 0; box_lo_y = 0; box_hi_y = 0;
    cross_acc = 0;
    perim_acc = 0;
    vtx_seen  = 0;
  endfunction

  // Floor square root, one root bit per pair of radicand bits
  function automatic longint unsigned floor_root(longint unsigned rad);
    longint unsigned root;
    longint unsigned rem;
    longint unsigned trial;
    root = 0;
    rem  = 0;
    for (int i = 16; i >= 0; i--) begin
      rem   = (rem << 2) | ((rad >> (2 * i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Add one edge to the shoelace sum and the perimeter, both saturating
  function automatic void add_side(longint ax, longint ay, longint bx, longint by);
    longint          term;
    longint          dx;
    longint          dy;
    longint unsigned len;
    term = ax * by - bx * ay;
    dx   = (bx > ax) ? bx - ax : ax - bx;
    dy   = (by > ay) ? by - ay : ay - by;
    len  = floor_root(longint'(dx * dx + dy * dy));
    if (term > TERM_CLAMP) term = TERM_CLAMP;
    if (term < -TERM_CLAMP) term = -TERM_CLAMP;
    cross_acc = cross_acc + term;
    if (cross_acc > longint'(CROSS_LIMIT)) cross_acc = longint'(CROSS_LIMIT);
    if (cross_acc < -longint'(CROSS_LIMIT)) cross_acc = -longint'(CROSS_LIMIT);
    if (len >= PERIM_MAX || perim_acc + len >= PERIM_MAX) perim_acc = PERIM_MAX;
    else perim_acc = perim_acc + len;
  endfunction

  // Take one vertex; return 1 with the polygon's metrics when it closes the polygon
  function automatic bit take_vertex(pmso_in_t v, output pmso_out_t res);
    longint          x;
    longint          y;
    longint          mag;
    longint unsigned w;
    longint unsigned h;
    x   = longint'($signed(v.x));
    y   = longint'($signed(v.y));
    res = '0;
    if (vtx_seen == 0) begin
      poly_first_x = x;
      poly_first_y = y;
      box_lo_x = x; box_hi_x = x;
      box_lo_y = y; box_hi_y = y;
    end else begin
      add_side(poly_prev_x, poly_prev_y, x, y);
      if (x < box_lo_x) box_lo_x = x;
      if (x > box_hi_x) box_hi_x = x;
      if (y < box_lo_y) box_lo_y = y;
      if (y > box_hi_y) box_hi_y = y;
    end
    poly_prev_x = x;
    poly_prev_y = y;
    if (vtx_seen < MAX_VERTICES) vtx_seen++;
    if (!v.last) return 1'b0;

    res.point_count = (vtx_seen > COUNT_OUT_MAX) ? COUNT_OUT_MAX : vtx_seen[COUNT_OUT_BITS-1:0];
    if (vtx_seen < MIN_POINTS) begin
      // too few points: geometry stays zero
      res.too_small = filt_on;
    end else begin
      add_side(x, y, poly_first_x, poly_first_y);
      w   = longint'(box_hi_x - box_lo_x);
      h   = longint'(box_hi_y - box_lo_y);
      if (w > 64'hFFFF) w = 64'hFFFF;
      if (h > 64'hFFFF) h = 64'hFFFF;
      mag = (cross_acc < 0) ? -cross_acc : cross_acc;
      if (mag > AREA_MAX) mag = AREA_MAX;
      res.min_x        = box_lo_x[COORD_BITS-1:0];
      res.max_x        = box_hi_x[COORD_BITS-1:0];
      res.min_y        = box_lo_y[COORD_BITS-1:0];
      res.max_y        = box_hi_y[COORD_BITS-1:0];
      res.box_width    = w[COORD_BITS-1:0];
      res.box_height   = h[COORD_BITS-1:0];
      res.doubled_area = mag[AREA_BITS-1:0];
      res.perimeter    = perim_acc[PERIM_BITS-1:0];
      if (filt_on && (res.doubled_area < thr_area || res.box_width < thr_width ||
                      res.box_height < thr_height || res.perimeter < thr_perim))
        res.too_small = 1'b1;
    end
    clear_shape();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- monitors

  // Track register writes
  always @(posedge clk_i) begin
    if (cfg_fire) begin
      case (pmso_reg_e'(cfg_if.data.index))
        REG_FILTER_ENABLED:   filt_on    <= cfg_if.data.value[0];
        REG_MIN_DOUBLED_AREA: thr_area   <= cfg_if.data.value[AREA_BITS-1:0];
        REG_MIN_WIDTH:        thr_width  <= cfg_if.data.value[COORD_BITS-1:0];
        REG_MIN_HEIGHT:       thr_height <= cfg_if.data.value[COORD_BITS-1:0];
        REG_MIN_PERIMETER:    thr_perim  <= cfg_if.data.value[PERIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Predict on every vertex transfer
  always @(posedge clk_i) begin
    pmso_out_t predicted;
    if (vtx_fire) begin
      if (take_vertex(vtx_if.data, predicted))
        metrics_due.insert(metrics_due.size(), row_is_typed ? row_want : predicted);
    end
  end

  function automatic void note_fault(string what, longint unsigned want, longint unsigned got);
    fault_count++;
    if (fault_count <= REPORT_LIMIT)
      $display("result %0d: %s expected 0x%0h, got 0x%0h", results_seen, what, want, got);
  endfunction

  function automatic void compare_field(string what, longint unsigned want,
                                        longint unsigned got);
    if (want != got) note_fault(what, want, got);
  endfunction

  // Check every result transfer against the oldest expectation
  always @(posedge clk_i) begin
    pmso_out_t want;
    pmso_out_t got;
    if (res_fire) begin
      got = res_if.data;
      results_seen++;
      if (metrics_due.size() == 0) begin
        note_fault("unexpected result, point_count", 0, got.point_count);
      end else begin
        want = metrics_due.pop_front();
        compare_field("min_x", want.min_x, got.min_x);
        compare_field("max_x", want.max_x, got.max_x);
        compare_field("min_y", want.min_y, got.min_y);
        compare_field("max_y", want.max_y, got.max_y);
        compare_field("box_width", want.box_width, got.box_width);
        compare_field("box_height", want.box_height, got.box_height);
        compare_field("doubled_area", want.doubled_area, got.doubled_area);
        compare_field("perimeter", want.perimeter, got.perimeter);
        compare_field("point_count", want.point_count, got.point_count);
        compare_field("too_small", want.too_small, got.too_small);
      end
    end
  end

  // Drop the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (vtx_fire || res_fire || cfg_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- drivers

  // Mostly no gap, some short ones, a few long ones; none in a calm stretch
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the result channel at random
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      res_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      res_if.ready <= 1'b1;
      hold_left = pick_gap();
    end
  end

  task automatic send_vertex(pmso_in_t v, bit typed, pmso_out_t want);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      vtx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    row_is_typed = typed;
    row_want     = want;
    vtx_if.valid <= 1'b1;
    vtx_if.data  <= v;
    @(posedge clk_i);
    while (!vtx_if.ready) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] value);
    pmso_cfg_t c;
    c.index = index;
    c.value = value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= c;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  // Release both request channels, wait for every result, then let the block go quiet
  task automatic drain();
    @(negedge clk_i);
    vtx_if.valid <= 1'b0;
    cfg_if.valid <= 1'b0;
    while (metrics_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Thresholds: first all zero, then all at maximum, then filter off; random after that
  task automatic apply_setting(int unsigned phase);
    logic [CFG_DATA_BITS-1:0] fe;
    logic [AREA_BITS-1:0]     area;
    logic [COORD_BITS-1:0]    w;
    logic [COORD_BITS-1:0]    h;
    logic [PERIM_BITS-1:0]    p;
    case (phase)
      0: begin
        fe = CFG_DATA_BITS'(1); area = '0; w = '0; h = '0; p = '0;
      end
      1: begin
        fe = '1; area = '1; w = '1; h = '1; p = '1;
      end
      2: begin
        fe = CFG_DATA_BITS'({$urandom, $urandom});
        fe[0] = 1'b0;
        area = '1; w = '1; h = '1; p = '1;
      end
      default: begin
        fe    = CFG_DATA_BITS'({$urandom, $urandom});
        fe[0] = ($urandom_range(0, 3) != 0);
        area  = AREA_BITS'({$urandom, $urandom} >> $urandom_range(24, 63));
        w     = COORD_BITS'($urandom >> $urandom_range(18, 31));
        h     = COORD_BITS'($urandom >> $urandom_range(18, 31));
        p     = PERIM_BITS'({$urandom, $urandom} >> $urandom_range(48, 63));
      end
    endcase
    // upper data bits carry noise that the block must ignore
    write_reg(REG_FILTER_ENABLED, fe);
    write_reg(REG_MIN_DOUBLED_AREA, area);
    write_reg(REG_MIN_WIDTH, {32'($urandom), w});
    write_reg(REG_MIN_HEIGHT, {32'($urandom), h});
    write_reg(REG_MIN_PERIMETER, {8'($urandom), p});
    write_reg(CFG_INDEX_BITS'($urandom_range(REG_MIN_PERIMETER + 1, (1 << CFG_INDEX_BITS) - 1)),
              CFG_DATA_BITS'({$urandom, $urandom}));
    // release the write channel before any vertex goes out
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [COORD_BITS-1:0] pick_coord(shape_e shape,
                                                       logic [COORD_BITS-1:0] centre,
                                                       int unsigned span);
    case (shape)
      SHAPE_CLUSTER: return COORD_BITS'(centre + $urandom_range(0, 2 * span) - span);
      SHAPE_CORNERS: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          3: return 16'hFFFF;
          default: return COORD_BITS'($urandom);
        endcase
      end
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  // One polygon: mostly small clusters of a handful of points, some broken or large
  task automatic send_random_polygon();
    int unsigned           sides;
    int unsigned           span;
    int unsigned           r;
    shape_e                shape;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    pmso_in_t              v;
    r = $urandom_range(0, 99);
    if (r < 8) sides = $urandom_range(1, 2);
    else if (r < 93) sides = $urandom_range(3, 10);
    else sides = $urandom_range(11, 48);
    r = $urandom_range(0, 99);
    shape = (r < 20) ? SHAPE_SCATTER : (r < 85) ? SHAPE_CLUSTER : SHAPE_CORNERS;
    span  = 1 << $urandom_range(2, 12);
    cx    = COORD_BITS'($urandom);
    cy    = COORD_BITS'($urandom);
    for (int i = 0; i < sides; i++) begin
      v.x    = pick_coord(shape, cx, span);
      v.y    = pick_coord(shape, cy, span);
      v.last = (i == sides - 1);
      send_vertex(v, 1'b0, '0);
      stim_items++;
    end
  endtask

  function automatic pmso_out_t metrics(
    logic [COORD_BITS-1:0] lx, logic [COORD_BITS-1:0] hx,
    logic [COORD_BITS-1:0] ly, logic [COORD_BITS-1:0] hy,
    logic [COORD_BITS-1:0] w, logic [COORD_BITS-1:0] h,
    logic [AREA_BITS-1:0] area, logic [PERIM_BITS-1:0] perim,
    logic [COUNT_OUT_BITS-1:0] count, logic small_flag);
    pmso_out_t m;
    m.min_x = lx; m.max_x = hx; m.min_y = ly; m.max_y = hy;
    m.box_width = w; m.box_height = h;
    m.doubled_area = area; m.perimeter = perim;
    m.point_count = count; m.too_small = small_flag;
    return m;
  endfunction

  function automatic void add_row(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                  logic last, bit typed, pmso_out_t want);
    vertex_row_t row;
    row.vtx.x    = x;
    row.vtx.y    = y;
    row.vtx.last = last;
    row.typed    = typed;
    row.want     = want;
    plan.insert(plan.size(), row);
  endfunction

  // ---------------------------------------------------------------- sequence

  initial begin
    int unsigned phase;
    int unsigned phase_end;

    // hold every input at a known value, then reset
    rst_ni       = 1'b0;
    vtx_if.valid = 1'b0;
    vtx_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    res_if.ready = 1'b0;
    hold_left    = 0;
    calm         = 1'b0;
    row_is_typed = 1'b0;
    row_want     = '0;
    fault_count  = 0;
    results_seen = 0;
    stim_items   = 0;
    quiet_cycles = 0;
    filt_on      = 1'b0;
    thr_area     = '0;
    thr_width    = '0;
    thr_height   = '0;
    thr_perim    = '0;
    clear_shape();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed polygons under reset thresholds (filter off)
    // single point, then two points: geometry all zero
    add_row(16'h7FFF, 16'h8000, 1'b1, 1'b1, metrics(0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    add_row(16'h8000, 16'h8000, 1'b0, 1'b0, '0);
    add_row(16'h7FFF, 16'h7FFF, 1'b1, 1'b1, metrics(0, 0, 0, 0, 0, 0, 0, 0, 2, 0));
    // full-range right triangle: widest box, largest single edge terms
    add_row(16'h8000, 16'h8000, 1'b0, 1'b0, '0);
    add_row(16'h7FFF, 16'h8000, 1'b0, 1'b0, '0);
    add_row(16'h8000, 16'h7FFF, 1'b1, 1'b1,
            metrics(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                    48'd4294836225, 40'd223750, 3, 0));
    // 16-by-16 square, anticlockwise
    add_row(16'd0, 16'd0, 1'b0, 1'b0, '0);
    add_row(16'd16, 16'd0, 1'b0, 1'b0, '0);
    add_row(16'd16, 16'd16, 1'b0, 1'b0, '0);
    add_row(16'd0, 16'd16, 1'b1, 1'b0, '0);
    // clockwise triangle: negative shoelace sum
    add_row(16'd0, 16'd0, 1'b0, 1'b0, '0);
    add_row(16'd0, 16'd160, 1'b0, 1'b0, '0);
    add_row(16'd160, 16'd0, 1'b1, 1'b0, '0);
    // collinear points: zero area
    add_row(16'hFFFB, 16'hFFFB, 1'b0, 1'b0, '0);
    add_row(16'd0, 16'd0, 1'b0, 1'b0, '0);
    add_row(16'd5, 16'd5, 1'b1, 1'b0, '0);
    // one point three times: zero box, zero perimeter
    add_row(16'd100, 16'd100, 1'b0, 1'b0, '0);
    add_row(16'd100, 16'd100, 1'b0, 1'b0, '0);
    add_row(16'd100, 16'd100, 1'b1, 1'b0, '0);
    // mixed extremes around minus one
    add_row(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0);
    add_row(16'h8000, 16'h0000, 1'b0, 1'b0, '0);
    add_row(16'h0000, 16'h7FFF, 1'b0, 1'b0, '0);
    add_row(16'h7FFF, 16'h8000, 1'b1, 1'b0, '0);

    foreach (plan[i]) send_vertex(plan[i].vtx, plan[i].typed, plan[i].want);

    // Random polygons, one threshold setting per phase
    phase = 0;
    while (stim_items < RANDOM_ITEMS) begin
      drain();
      apply_setting(phase);
      calm      = (phase % 3 == 2);
      phase_end = stim_items + PHASE_ITEMS;
      while (stim_items < phase_end) send_random_polygon();
      phase++;
    end
    calm = 1'b0;
    drain();

    if (fault_count == 0 && metrics_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
